/* hdl/escape_time_fractal_iterator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time fractal iterator
// Shared property templates; every check is clocked on clock and masked by reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/etf_pkg.sv */
// ----------------------------------------------------------------------------
// etf_pkg
// Shared constants, codes and types of the escape-time fractal iterator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etf_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int ITER_WIDTH_DEF  = 16;
   localparam int PIXEL_WIDTH_DEF = 12;

   // Integer bits of the fixed-point format; the rest are fraction bits.
   localparam int INT_BITS = 4;

   localparam int THRESH_WIDTH    = 31;
   localparam int LIMIT_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 31;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VARIANT   = 2'd2;

   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 31'h4000_0000;
   localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET  = 16'd256;

   typedef enum logic [1:0] {
      VAR_STANDARD,
      VAR_BURNING_SHIP,
      VAR_PLUME,
      VAR_TRICORN
   } etf_variant_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD
   } etf_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } etf_q_status_type;

endpackage

/* hdl/etf_front.sv */
// ----------------------------------------------------------------------------
// etf_front
// Accepts pixel beats, flags those that need no iteration and pushes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etf_front import etf_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF,
   parameter int ENTRY_WIDTH = 1 + 2 * PIXEL_WIDTH + 4 * COORD_WIDTH
) (
   input  logic                          start,
   output logic                          busy,
   input  logic        [PIXEL_WIDTH-1:0] req_pixel_x,
   input  logic        [PIXEL_WIDTH-1:0] req_pixel_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_real,
   input  logic signed [COORD_WIDTH-1:0] req_start_imag,
   input  logic signed [COORD_WIDTH-1:0] req_const_real,
   input  logic signed [COORD_WIDTH-1:0] req_const_imag,
   input  logic        [LIMIT_WIDTH-1:0] max_iterations,
   input  etf_q_status_type              q_status,
   output logic                          push,
   output logic        [ENTRY_WIDTH-1:0] push_data
);

   logic skip;

   // With a zero limit the result is known at once: count zero, inside the set.
   assign skip = (max_iterations == '0);
   assign busy = q_status.full;
   assign push = start && !busy;
   assign push_data = {skip, req_pixel_x, req_pixel_y, req_start_real, req_start_imag,
                       req_const_real, req_const_imag};

endmodule

/* hdl/etf_queue.sv */
// ----------------------------------------------------------------------------
// etf_queue
// Short first-in first-out buffer between the front and the iteration engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etf_queue import etf_pkg::*; #(
   parameter int ENTRY_WIDTH = 1,
   parameter int DEPTH       = QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [ENTRY_WIDTH-1:0] push_data,
   input  logic                   pop,
   output logic [ENTRY_WIDTH-1:0] pop_data,
   output etf_q_status_type       q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [ENTRY_WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_data       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/etf_core.sv */
// ----------------------------------------------------------------------------
// etf_core
// Iteration engine: each complex step is a multiply state, then an update state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etf_core import etf_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int ITER_WIDTH  = ITER_WIDTH_DEF,
   parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF,
   parameter int ENTRY_WIDTH = 1 + 2 * PIXEL_WIDTH + 4 * COORD_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  etf_q_status_type        q_status,
   output logic                    pop,
   input  logic [ENTRY_WIDTH-1:0]  pop_data,
   input  logic [THRESH_WIDTH-1:0] escape_threshold,
   input  logic [LIMIT_WIDTH-1:0]  max_iterations,
   input  etf_variant_type         fractal_variant,
   output logic                    rsp_valid,
   output logic [PIXEL_WIDTH-1:0]  rsp_out_x,
   output logic [PIXEL_WIDTH-1:0]  rsp_out_y,
   output logic [ITER_WIDTH-1:0]   rsp_iteration_count,
   output logic                    rsp_inside_set
);

   localparam int FRAC  = COORD_WIDTH - INT_BITS;
   localparam int PROD_W = 2 * COORD_WIDTH;
   localparam int SCL_W = COORD_WIDTH + INT_BITS;
   localparam int SUM_W = (COORD_WIDTH + 6 > THRESH_WIDTH + 1) ? COORD_WIDTH + 6
                                                              : THRESH_WIDTH + 1;
   localparam int CNT_W = (ITER_WIDTH > LIMIT_WIDTH) ? ITER_WIDTH : LIMIT_WIDTH;

   function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'($signed({1'b0, {(COORD_WIDTH - 1){1'b1}}}));
      lo = -hi - 1;
      if (v > hi) begin
         return hi[COORD_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[COORD_WIDTH-1:0];
      end
      return v[COORD_WIDTH-1:0];
   endfunction

   etf_state_type state_ff, state_in;

   logic                          q_skip;
   logic        [PIXEL_WIDTH-1:0] q_x, q_y;
   logic signed [COORD_WIDTH-1:0] q_zr, q_zi, q_cr, q_ci;

   logic        [PIXEL_WIDTH-1:0] x_ff, y_ff;
   logic signed [COORD_WIDTH-1:0] zr_ff, zi_ff, cr_ff, ci_ff;
   logic        [CNT_W-1:0]       count_ff;
   logic signed [PROD_W-1:0]      prod_rr_ff, prod_ii_ff, prod_ri_ff;

   logic signed [PROD_W-1:0] mul_rr, mul_ii, mul_ri;
   logic signed [SCL_W-1:0]  sr, si, p;
   logic signed [SUM_W-1:0]  sr_ext, si_ext, p_ext, p_abs, k, mag, thr_ext;
   logic signed [SUM_W-1:0]  new_r, new_i;
   logic                     escaped, limit_hit, stop;
   logic                     emit, emit_skip;

   logic                   rsp_valid_ff;
   logic [PIXEL_WIDTH-1:0] rsp_x_ff, rsp_y_ff;
   logic [ITER_WIDTH-1:0]  rsp_count_ff;
   logic                   rsp_inside_ff;

   assign {q_skip, q_x, q_y, q_zr, q_zi, q_cr, q_ci} = pop_data;

   assign mul_rr = zr_ff * zr_ff;
   assign mul_ii = zi_ff * zi_ff;
   assign mul_ri = zr_ff * zi_ff;

   // Dropping the fraction bits of a two's-complement product rounds toward minus infinity.
   assign sr = prod_rr_ff[PROD_W-1:FRAC];
   assign si = prod_ii_ff[PROD_W-1:FRAC];
   assign p  = prod_ri_ff[PROD_W-1:FRAC];

   assign sr_ext  = SUM_W'(sr);
   assign si_ext  = SUM_W'(si);
   assign p_ext   = SUM_W'(p);
   assign p_abs   = (p_ext < 0) ? -p_ext : p_ext;
   assign mag     = sr_ext + si_ext;
   assign thr_ext = $signed({{(SUM_W - THRESH_WIDTH){1'b0}}, escape_threshold});

   assign escaped   = !(mag < thr_ext);
   assign limit_hit = (count_ff >= CNT_W'(max_iterations));
   assign stop      = escaped || limit_hit;

   always_comb begin
      case (fractal_variant)
         VAR_STANDARD:     k = p_ext + p_ext;
         VAR_BURNING_SHIP: k = p_abs + p_abs;
         VAR_PLUME:        k = p_ext;
         VAR_TRICORN:      k = -(p_ext + p_ext);
         default:          k = p_ext + p_ext;
      endcase
   end

   assign new_r = sr_ext - si_ext + SUM_W'(cr_ff);
   assign new_i = k + SUM_W'(ci_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && !q_skip) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_UPD;
         ST_UPD: state_in = stop ? ST_IDLE : ST_MUL;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      emit_skip = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop       = !q_status.empty;
            emit_skip = !q_status.empty && q_skip;
            emit      = emit_skip;
         end
         ST_MUL: ;
         ST_UPD: emit = stop;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         x_ff     <= q_x;
         y_ff     <= q_y;
         zr_ff    <= q_zr;
         zi_ff    <= q_zi;
         cr_ff    <= q_cr;
         ci_ff    <= q_ci;
         count_ff <= '0;
      end else if (state_ff == ST_UPD && !stop) begin
         zr_ff    <= sat(new_r);
         zi_ff    <= sat(new_i);
         count_ff <= count_ff + 1'b1;
      end
      if (state_ff == ST_MUL) begin
         prod_rr_ff <= mul_rr;
         prod_ii_ff <= mul_ii;
         prod_ri_ff <= mul_ri;
      end
      if (emit_skip) begin
         rsp_x_ff      <= q_x;
         rsp_y_ff      <= q_y;
         rsp_count_ff  <= '0;
         rsp_inside_ff <= 1'b1;
      end else if (emit) begin
         rsp_x_ff      <= x_ff;
         rsp_y_ff      <= y_ff;
         rsp_count_ff  <= count_ff[ITER_WIDTH-1:0];
         rsp_inside_ff <= (count_ff == CNT_W'(max_iterations));
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_x           = rsp_x_ff;
   assign rsp_out_y           = rsp_y_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_inside_set      = rsp_inside_ff;

endmodule

/* hdl/escape_time_fractal_iterator.sv */
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Escape-time iteration of one pixel for Mandelbrot-type fractals in Q4.28.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel beat is taken on a rising edge with start high and busy low; busy
//   is high while the two-entry queue in front of the iteration engine is full.
//   Each result beat is shown for one cycle with rsp_valid high and must be
//   taken then; the receiver cannot stall the block.
//   Each complex step of the engine is a registered multiply state followed by
//   an update state (the shift, escape test, add and saturation). A pixel that
//   stops after n steps occupies the engine from its load in the idle state
//   through a multiply and an update state for each step and for the final
//   escape test, whose update state registers its result beat.
//   Pixels with a zero iteration limit are answered the cycle after they are
//   taken, once they reach the engine.
//   Registers are written through csr_we, csr_index and csr_wdata; the user
//   must write them only while the block is idle, which it does not enforce.
//   Unknown indexes are ignored. Synchronous reset empties the queue, idles
//   the engine, drops any pending result and restores the register defaults
//   (threshold 4.0, limit 256, standard variant).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escape_time_fractal_iterator import etf_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int ITER_WIDTH  = ITER_WIDTH_DEF,
   parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic        [PIXEL_WIDTH-1:0] req_pixel_x,
   input  logic        [PIXEL_WIDTH-1:0] req_pixel_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_real,
   input  logic signed [COORD_WIDTH-1:0] req_start_imag,
   input  logic signed [COORD_WIDTH-1:0] req_const_real,
   input  logic signed [COORD_WIDTH-1:0] req_const_imag,
   output logic                          rsp_valid,
   output logic        [PIXEL_WIDTH-1:0] rsp_out_x,
   output logic        [PIXEL_WIDTH-1:0] rsp_out_y,
   output logic        [ITER_WIDTH-1:0]  rsp_iteration_count,
   output logic                          rsp_inside_set,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata
);

`include "escape_time_fractal_iterator_macros.svh"

   localparam int ENTRY_WIDTH = 1 + 2 * PIXEL_WIDTH + 4 * COORD_WIDTH;

   logic [THRESH_WIDTH-1:0] escape_threshold_ff;
   logic [LIMIT_WIDTH-1:0]  max_iterations_ff;
   etf_variant_type         fractal_variant_ff;

   etf_q_status_type       q_status;
   logic                   push, pop;
   logic [ENTRY_WIDTH-1:0] push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_threshold_ff <= THRESH_RESET;
         max_iterations_ff   <= LIMIT_RESET;
         fractal_variant_ff  <= VAR_STANDARD;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: escape_threshold_ff <= csr_wdata[THRESH_WIDTH-1:0];
            CSR_LIMIT:     max_iterations_ff   <= csr_wdata[LIMIT_WIDTH-1:0];
            CSR_VARIANT:   fractal_variant_ff  <= etf_variant_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   etf_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .PIXEL_WIDTH (PIXEL_WIDTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_front (
      .start          (start),
      .busy           (busy),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_start_real (req_start_real),
      .req_start_imag (req_start_imag),
      .req_const_real (req_const_real),
      .req_const_imag (req_const_imag),
      .max_iterations (max_iterations_ff),
      .q_status       (q_status),
      .push           (push),
      .push_data      (push_data)
   );

   etf_queue #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .DEPTH       (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   etf_core #(
      .COORD_WIDTH (COORD_WIDTH),
      .ITER_WIDTH  (ITER_WIDTH),
      .PIXEL_WIDTH (PIXEL_WIDTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .pop                 (pop),
      .pop_data            (pop_data),
      .escape_threshold    (escape_threshold_ff),
      .max_iterations      (max_iterations_ff),
      .fractal_variant     (fractal_variant_ff),
      .rsp_valid           (rsp_valid),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_inside_set      (rsp_inside_set)
   );

   `ETF_ASSERT_SAME(a_no_pop_empty, pop, !q_status.empty, "pop from an empty queue")
   `ETF_ASSERT_SAME(a_no_push_full, push, !q_status.full, "push into a full queue")
   `ETF_ASSERT_NEXT(a_beat_queued, start && !busy, !q_status.empty, "accepted beat not queued")

endmodule

/* sim/escape_time_fractal_iterator_test.sv */
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_test
// Self-checking bench for the escape-time fractal iterator. A short table of
// directed pixels (register extremes, every variant, saturation, zero limit and
// zero threshold) is followed by phases of random pixels under changing register
// settings and sender idle rates. Every result beat is checked in order, typed
// rows against the table and others against a cycle-free fixed-point model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escape_time_fractal_iterator_test;
   import etf_pkg::*;

   localparam int PIX_W     = PIXEL_WIDTH_DEF;
   localparam int COORD_W   = COORD_WIDTH_DEF;
   localparam int ITER_W    = ITER_WIDTH_DEF;
   localparam int FRAC_BITS = COORD_W - INT_BITS;

   localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   localparam int     NUM_PHASES      = 8;
   localparam int     PIXELS_PER_PHASE = 200;
   localparam longint CYCLE_LIMIT     = 2000000;
   localparam int     IDLE_PERCENT [3] = '{0, 62, 31};

   typedef struct packed {
      logic [PIX_W-1:0]   x;
      logic [PIX_W-1:0]   y;
      logic [COORD_W-1:0] zr;
      logic [COORD_W-1:0] zi;
      logic [COORD_W-1:0] cr;
      logic [COORD_W-1:0] ci;
   } pixel_req_type;

   typedef struct packed {
      logic [PIX_W-1:0]  x;
      logic [PIX_W-1:0]  y;
      logic [ITER_W-1:0] count;
      logic              in_set;
   } pixel_outcome_type;

   typedef struct packed {
      logic [THRESH_WIDTH-1:0] thr;
      logic [LIMIT_WIDTH-1:0]  lim;
      etf_variant_type         variant;
      pixel_req_type           px;
      logic                    typed;
      logic [ITER_W-1:0]       want_count;
      logic                    want_in_set;
   } probe_row_type;

   localparam int NUM_PROBES = 20;

   // Rows are grouped by register setting; the first row runs on reset values.
   localparam probe_row_type PROBES [NUM_PROBES] = '{
      '{31'h4000_0000, 16'd256, VAR_STANDARD,
        '{12'd0, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 16'd256, 1'b1},
      '{31'h4000_0000, 16'd256, VAR_STANDARD,
        '{12'd4095, 12'd4095, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0}, 1'b1, 16'd0, 1'b0},
      '{31'h4000_0000, 16'd256, VAR_STANDARD,
        '{12'd1, 12'd2, 32'h0, 32'h8000_0000, 32'h0, 32'h0}, 1'b1, 16'd0, 1'b0},
      '{31'h4000_0000, 16'd256, VAR_STANDARD,
        '{12'd4095, 12'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, 16'd1, 1'b0},
      '{31'h4000_0000, 16'd256, VAR_STANDARD,
        '{12'hAAA, 12'h555, 32'h0, 32'h0, 32'hF400_0000, 32'h0199_999A}, 1'b0, 16'd0, 1'b0},
      '{31'h4000_0000, 16'd256, VAR_STANDARD,
        '{12'h555, 12'hAAA, 32'h0, 32'h0, 32'h0400_0000, 32'h0}, 1'b0, 16'd0, 1'b0},
      '{31'h4000_0000, 16'd64, VAR_STANDARD,
        '{12'd10, 12'd20, 32'h04CC_CCCD, 32'hF800_0000, 32'hF333_3333, 32'h027E_F9DB},
        1'b0, 16'd0, 1'b0},
      '{31'h4000_0000, 16'd64, VAR_BURNING_SHIP,
        '{12'd11, 12'd21, 32'h0800_0000, 32'hF800_0000, 32'hE400_0000, 32'hFF85_1EB8},
        1'b0, 16'd0, 1'b0},
      '{31'h4000_0000, 16'd64, VAR_PLUME,
        '{12'd12, 12'd22, 32'h1000_0000, 32'h1000_0000, 32'hF800_0000, 32'h0800_0000},
        1'b0, 16'd0, 1'b0},
      '{31'h4000_0000, 16'd64, VAR_TRICORN,
        '{12'd13, 12'd23, 32'hF800_0000, 32'h0C00_0000, 32'h0199_999A, 32'hF666_6666},
        1'b0, 16'd0, 1'b0},
      '{31'h7FFF_FFFF, 16'd8, VAR_STANDARD,
        '{12'd30, 12'd40, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000}, 1'b0, 16'd0, 1'b0},
      '{31'h7FFF_FFFF, 16'd8, VAR_STANDARD,
        '{12'd31, 12'd41, 32'h1800_0000, 32'h1800_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        1'b0, 16'd0, 1'b0},
      '{31'h7FFF_FFFF, 16'd8, VAR_STANDARD,
        '{12'd32, 12'd42, 32'h0, 32'h1800_0000, 32'h8000_0000, 32'h8000_0000},
        1'b0, 16'd0, 1'b0},
      '{31'h0, 16'd256, VAR_STANDARD,
        '{12'd50, 12'd60, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 16'd0, 1'b0},
      '{31'h4000_0000, 16'd0, VAR_STANDARD,
        '{12'd51, 12'd61, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 16'd0, 1'b1},
      '{31'h4000_0000, 16'd0, VAR_STANDARD,
        '{12'd52, 12'd62, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0}, 1'b1, 16'd0, 1'b1},
      '{31'h0, 16'd0, VAR_STANDARD,
        '{12'd53, 12'd63, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 16'd0, 1'b1},
      '{31'h4000_0000, 16'd1, VAR_PLUME,
        '{12'd54, 12'd64, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 16'd1, 1'b1},
      '{31'h7FFF_FFFF, 16'd65535, VAR_TRICORN,
        '{12'd55, 12'd65, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 16'd65535, 1'b1},
      '{31'h7FFF_FFFF, 16'd65535, VAR_TRICORN,
        '{12'd56, 12'd66, 32'h0, 32'h0, 32'h1000_0000, 32'h1000_0000}, 1'b0, 16'd0, 1'b0}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [PIX_W-1:0]           req_pixel_x = '0;
   logic [PIX_W-1:0]           req_pixel_y = '0;
   logic signed [COORD_W-1:0]  req_start_real = '0;
   logic signed [COORD_W-1:0]  req_start_imag = '0;
   logic signed [COORD_W-1:0]  req_const_real = '0;
   logic signed [COORD_W-1:0]  req_const_imag = '0;
   logic                       rsp_valid;
   logic [PIX_W-1:0]           rsp_out_x;
   logic [PIX_W-1:0]           rsp_out_y;
   logic [ITER_W-1:0]          rsp_iteration_count;
   logic                       rsp_inside_set;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_THRESHOLD;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Register values the model iterates with, kept in step with every write.
   logic [THRESH_WIDTH-1:0] cfg_threshold = THRESH_RESET;
   logic [LIMIT_WIDTH-1:0]  cfg_limit     = LIMIT_RESET;
   etf_variant_type         cfg_variant   = VAR_STANDARD;

   pixel_outcome_type pending_outcomes [$];
   int                mismatches  = 0;
   longint            cycle_count = 0;

   escape_time_fractal_iterator u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_pixel_x         (req_pixel_x),
      .req_pixel_y         (req_pixel_y),
      .req_start_real      (req_start_real),
      .req_start_imag      (req_start_imag),
      .req_const_real      (req_const_real),
      .req_const_imag      (req_const_imag),
      .rsp_valid           (rsp_valid),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_inside_set      (rsp_inside_set),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic longint clamp_coord(input longint value);
      if (value > COORD_MAX) return COORD_MAX;
      if (value < COORD_MIN) return COORD_MIN;
      return value;
   endfunction

   // Squares and the cross product are exact, then floored back to Q4.28.
   function automatic pixel_outcome_type iterate_pixel(input pixel_req_type px);
      longint            zr, zi, cr, ci, sq_r, sq_i, cross_term, twist, bound;
      int unsigned       steps;
      pixel_outcome_type outcome;
      zr    = longint'($signed(px.zr));
      zi    = longint'($signed(px.zi));
      cr    = longint'($signed(px.cr));
      ci    = longint'($signed(px.ci));
      bound = longint'(cfg_threshold);
      steps = 0;
      sq_r  = (zr * zr) >>> FRAC_BITS;
      sq_i  = (zi * zi) >>> FRAC_BITS;
      while (sq_r + sq_i < bound && steps < cfg_limit) begin
         cross_term = (zr * zi) >>> FRAC_BITS;
         case (cfg_variant)
            VAR_BURNING_SHIP: twist = 2 * ((cross_term < 0) ? -cross_term : cross_term);
            VAR_PLUME:        twist = cross_term;
            VAR_TRICORN:      twist = -2 * cross_term;
            default:          twist = 2 * cross_term;
         endcase
         zr    = clamp_coord(sq_r - sq_i + cr);
         zi    = clamp_coord(twist + ci);
         steps = steps + 1;
         sq_r  = (zr * zr) >>> FRAC_BITS;
         sq_i  = (zi * zi) >>> FRAC_BITS;
      end
      outcome.x      = px.x;
      outcome.y      = px.y;
      outcome.count  = ITER_W'(steps);
      outcome.in_set = (steps == cfg_limit);
      return outcome;
   endfunction

   function automatic logic [COORD_W-1:0] region_coord();
      // Uniform over roughly -2.5 .. 2.5, where the interesting orbits live.
      return COORD_W'($urandom_range(0, 32'h5000_0000)) - 32'h2800_0000;
   endfunction

   function automatic logic [COORD_W-1:0] edge_coord();
      case ($urandom_range(0, 4))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return 32'h1;
         default: return '1;
      endcase
   endfunction

   function automatic pixel_req_type random_pixel();
      pixel_req_type px;
      int            mode;
      px.x = PIX_W'($urandom_range(0, 4095));
      px.y = PIX_W'($urandom_range(0, 4095));
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
         // Mandelbrot style: orbit starts at the origin.
         px.zr = '0;
         px.zi = '0;
         px.cr = region_coord();
         px.ci = region_coord();
      end else if (mode < 8) begin
         px.zr = region_coord();
         px.zi = region_coord();
         px.cr = region_coord();
         px.ci = region_coord();
      end else if (mode == 8) begin
         px.zr = $urandom;
         px.zi = $urandom;
         px.cr = $urandom;
         px.ci = $urandom;
      end else begin
         px.zr = edge_coord();
         px.zi = edge_coord();
         px.cr = edge_coord();
         px.ci = edge_coord();
      end
      return px;
   endfunction

   // Holds the pixel on the request ports until the block takes the beat.
   task automatic send_pixel(input pixel_req_type px, input logic typed,
                             input logic [ITER_W-1:0] want_count, input logic want_in_set);
      pixel_outcome_type outcome;
      start          <= 1'b1;
      req_pixel_x    <= px.x;
      req_pixel_y    <= px.y;
      req_start_real <= px.zr;
      req_start_imag <= px.zi;
      req_const_real <= px.cr;
      req_const_imag <= px.ci;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (typed) begin
         outcome = '{px.x, px.y, want_count, want_in_set};
      end else begin
         outcome = iterate_pixel(px);
      end
      pending_outcomes.push_back(outcome);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Junk above the limit and variant register widths must be dropped by the block.
   task automatic apply_settings(input logic [THRESH_WIDTH-1:0] thr,
                                 input logic [LIMIT_WIDTH-1:0] lim,
                                 input etf_variant_type variant,
                                 input logic [CSR_DATA_WIDTH-1:0] junk);
      csr_we    <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= CSR_LIMIT;
      csr_wdata <= {junk[CSR_DATA_WIDTH-LIMIT_WIDTH-1:0], lim};
      @(posedge clock);
      csr_index <= CSR_VARIANT;
      csr_wdata <= {junk[CSR_DATA_WIDTH-3:0], variant};
      @(posedge clock);
      csr_we        <= 1'b0;
      cfg_threshold  = thr;
      cfg_limit      = lim;
      cfg_variant    = variant;
   endtask

   always @(posedge clock) begin
      pixel_outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result beat for pixel (%0d, %0d)", rsp_out_x, rsp_out_y);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_out_x !== want.x) begin
               $error("out_x: expected %0d, got %0d", want.x, rsp_out_x);
               mismatches++;
            end
            if (rsp_out_y !== want.y) begin
               $error("out_y: expected %0d, got %0d", want.y, rsp_out_y);
               mismatches++;
            end
            if (rsp_iteration_count !== want.count) begin
               $error("iteration_count: expected %0d, got %0d", want.count,
                      rsp_iteration_count);
               mismatches++;
            end
            if (rsp_inside_set !== want.in_set) begin
               $error("inside_set: expected %0d, got %0d", want.in_set, rsp_inside_set);
               mismatches++;
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [THRESH_WIDTH-1:0] thr;
      logic [LIMIT_WIDTH-1:0]  lim;
      etf_variant_type         variant;
      int                      idle_pct;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_PROBES; i++) begin
         if (PROBES[i].thr != cfg_threshold || PROBES[i].lim != cfg_limit ||
             PROBES[i].variant != cfg_variant) begin
            drain_results();
            apply_settings(PROBES[i].thr, PROBES[i].lim, PROBES[i].variant, '0);
         end
         send_pixel(PROBES[i].px, PROBES[i].typed, PROBES[i].want_count,
                    PROBES[i].want_in_set);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         case (phase % 4)
            0:       thr = THRESH_RESET;
            1:       thr = THRESH_WIDTH'($urandom_range(0, 32'h7FFF_FFFF));
            2:       thr = 31'h7FFF_FFFF;
            default: thr = THRESH_WIDTH'($urandom_range(32'h0100_0000, 32'h4000_0000));
         endcase
         // Small limits keep the run short; one phase runs at the default depth.
         if (phase == 5) begin
            lim = LIMIT_RESET;
         end else if (phase == 2) begin
            lim = LIMIT_WIDTH'($urandom_range(0, 3));
         end else begin
            lim = LIMIT_WIDTH'($urandom_range(1, 40));
         end
         if (phase < 4) begin
            variant = etf_variant_type'(phase % 4);
         end else begin
            variant = etf_variant_type'($urandom_range(0, 3));
         end
         idle_pct = IDLE_PERCENT[phase % 3];
         apply_settings(thr, lim, variant, CSR_DATA_WIDTH'($urandom));

         for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
            while ($urandom_range(0, 99) < idle_pct) begin
               start <= 1'b0;
               @(posedge clock);
            end
            // Now and then let the engine run completely dry before the next beat.
            if ($urandom_range(0, 63) == 0) drain_results();
            send_pixel(random_pixel(), 1'b0, '0, 1'b0);
         end
      end

      drain_results();
      repeat (2 * int'(cfg_limit) + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
